@@ rtl/ibs_pkg.sv @@
// shared constants, types and helpers for the identity-by-state similarity core
// no dependencies; used by ibs_store and genotype_ibs_similarity_core
package ibs_pkg;

  localparam int PEOPLE     = 64;
  localparam int SNPS       = 1024;
  localparam int PERSON_W   = $clog2(PEOPLE);
  localparam int SNP_W      = $clog2(SNPS);
  localparam int ADDR_W     = PERSON_W + SNP_W;
  localparam int GENO_W     = 2;
  localparam int COUNT_W    = 11;
  localparam int WEIGHT_W   = 8;
  localparam int ACC_W      = $clog2(2 * SNPS) + 1;
  localparam int PROD_W     = ACC_W + WEIGHT_W;
  localparam int SIM_W      = 19;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [GENO_W-1:0]  GENO_MAX = 2'd2;
  localparam logic [COUNT_W-1:0] SNP_LIMIT = COUNT_W'(SNPS);
  localparam logic [SIM_W-1:0]   SIM_MAX = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SNP_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNP_WEIGHT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } state_t;

  // write request into the genotype store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [GENO_W-1:0] data;
  } store_wr_t;

  // shared alleles between two genotypes: 2 minus the absolute difference
  function automatic logic [1:0] ibs_term(input logic [GENO_W-1:0] a,
                                          input logic [GENO_W-1:0] b);
    logic [GENO_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (d >= 2'd2) ? 2'd0 : (2'd2 - d);
  endfunction

endpackage

@@ rtl/ibs_store.sv @@
// genotype store: one write port, two read ports with registered read data
// depends on ibs_pkg
module ibs_store (
  input  logic                            clk,
  input  ibs_pkg::store_wr_t              wr,
  input  logic [ibs_pkg::ADDR_W-1:0]      rd_addr_a,
  input  logic [ibs_pkg::ADDR_W-1:0]      rd_addr_b,
  output logic [ibs_pkg::GENO_W-1:0]      rd_data_a,
  output logic [ibs_pkg::GENO_W-1:0]      rd_data_b
);

  logic [ibs_pkg::GENO_W-1:0] mem [ibs_pkg::PEOPLE * ibs_pkg::SNPS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ rtl/genotype_ibs_similarity_core.sv @@
// Identity-by-state similarity core over a 64 x 1024 store of 2-bit genotypes.
// A write word (tuser 0) stores one genotype and gives no result.
// A query word (tuser 1) reads both individuals' rows one SNP column per cycle
// through the two read ports of the store, over min(snp_count, 1024) columns, then
// forms the weighted product and waits for the output register to empty; no word
// is accepted until the result has been loaded into the output register.
// The result is snp_weight times the summed shared-allele count.
// Reading a genotype that was never written gives an undefined result.
// Depends on ibs_pkg and ibs_store.
module genotype_ibs_similarity_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // person_a[5:0], person_b[11:6], snp[21:12], genotype[23:22]
  input  logic [ibs_pkg::IN_DATA_W-1:0]       s_tdata,
  // op[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // similarity[18:0], zeros above
  output logic [ibs_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [ibs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ibs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ibs_pkg::state_t state, state_next;

  logic [ibs_pkg::COUNT_W-1:0]  snp_count;
  logic [ibs_pkg::WEIGHT_W-1:0] snp_weight;

  logic [ibs_pkg::PERSON_W-1:0] person_a;
  logic [ibs_pkg::PERSON_W-1:0] person_b;
  logic [ibs_pkg::COUNT_W-1:0]  cnt;
  logic [ibs_pkg::COUNT_W-1:0]  n_eff;
  logic [ibs_pkg::ACC_W-1:0]    acc;
  logic [ibs_pkg::PROD_W-1:0]   prod;
  logic                         rd_valid;

  logic [ibs_pkg::PERSON_W-1:0] in_person_a;
  logic [ibs_pkg::PERSON_W-1:0] in_person_b;
  logic [ibs_pkg::SNP_W-1:0]    in_snp;
  logic [ibs_pkg::GENO_W-1:0]   in_geno;
  logic                         in_fire;
  logic                         last_issue;
  logic                         out_free;

  ibs_pkg::store_wr_t           wr;
  logic [ibs_pkg::ADDR_W-1:0]   rd_addr_a;
  logic [ibs_pkg::ADDR_W-1:0]   rd_addr_b;
  logic [ibs_pkg::GENO_W-1:0]   rd_data_a;
  logic [ibs_pkg::GENO_W-1:0]   rd_data_b;

  assign in_person_a = s_tdata[5:0];
  assign in_person_b = s_tdata[11:6];
  assign in_snp      = s_tdata[21:12];
  assign in_geno     = s_tdata[23:22];
  assign in_fire     = s_tvalid && s_tready;

  assign n_eff      = (snp_count > ibs_pkg::SNP_LIMIT) ? ibs_pkg::SNP_LIMIT : snp_count;
  assign last_issue = (cnt == n_eff - ibs_pkg::COUNT_W'(1));
  assign out_free   = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      snp_count  <= ibs_pkg::SNP_LIMIT;
      snp_weight <= ibs_pkg::WEIGHT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ibs_pkg::CFG_SNP_COUNT:  snp_count  <= cfg_data;
        ibs_pkg::CFG_SNP_WEIGHT: snp_weight <= cfg_data[ibs_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ibs_pkg::ST_IDLE: begin
        if (in_fire && s_tuser == ibs_pkg::OP_QUERY) begin
          state_next = (n_eff == '0) ? ibs_pkg::ST_MUL : ibs_pkg::ST_RUN;
        end
      end
      ibs_pkg::ST_RUN: begin
        if (last_issue) begin
          state_next = ibs_pkg::ST_DRAIN;
        end
      end
      ibs_pkg::ST_DRAIN: state_next = ibs_pkg::ST_MUL;
      ibs_pkg::ST_MUL:   state_next = ibs_pkg::ST_OUT;
      ibs_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = ibs_pkg::ST_IDLE;
        end
      end
      default: state_next = ibs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready  = (state == ibs_pkg::ST_IDLE);
    wr.we     = in_fire && (s_tuser == ibs_pkg::OP_WRITE);
    wr.addr   = {in_person_a, in_snp};
    wr.data   = (in_geno > ibs_pkg::GENO_MAX) ? ibs_pkg::GENO_MAX : in_geno;
    rd_addr_a = {person_a, cnt[ibs_pkg::SNP_W-1:0]};
    rd_addr_b = {person_b, cnt[ibs_pkg::SNP_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ibs_pkg::ST_IDLE;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ibs_pkg::ST_RUN);
      if (state == ibs_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath: column counter, accumulator, weight product
  always_ff @(posedge clk) begin
    if (in_fire && s_tuser == ibs_pkg::OP_QUERY) begin
      person_a <= in_person_a;
      person_b <= in_person_b;
      cnt      <= '0;
      acc      <= '0;
    end else begin
      if (state == ibs_pkg::ST_RUN) begin
        cnt <= cnt + ibs_pkg::COUNT_W'(1);
      end
      if (rd_valid) begin
        acc <= acc + ibs_pkg::ACC_W'(ibs_pkg::ibs_term(rd_data_a, rd_data_b));
      end
    end
    if (state == ibs_pkg::ST_MUL) begin
      prod <= ibs_pkg::PROD_W'(acc) * ibs_pkg::PROD_W'(snp_weight);
    end
    if (state == ibs_pkg::ST_OUT && out_free) begin
      m_tdata <= ibs_pkg::OUT_DATA_W'((prod > ibs_pkg::PROD_W'(ibs_pkg::SIM_MAX)) ?
                                      ibs_pkg::SIM_MAX : prod[ibs_pkg::SIM_W-1:0]);
    end
  end

  // writes happen only in idle and reads only while walking, so the ports never collide
  ibs_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == ibs_pkg::OP_WRITE) |=> (state == ibs_pkg::ST_IDLE))
    else $error("write word started a query walk");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ibs_pkg::ST_OUT))
    else $error("result raised outside the output state");

  a_read_from_walk: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ($past(state) == ibs_pkg::ST_RUN))
    else $error("read data marked valid without a walk cycle");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ibs_pkg::ST_RUN) |-> (acc <= {cnt, 1'b0}))
    else $error("accumulator above two per column read");
`endif

endmodule
